FILE: hw/rtl/wpd_pkg.sv
`default_nettype none

package wpd_pkg;

  // Widths of the payload fields and registers
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned POS_W      = 32;
  localparam int unsigned INTERVAL_W = 16;
  localparam int unsigned CHCNT_W    = 2;
  localparam int unsigned LOOP_W     = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // Channel limit
  localparam int unsigned MAX_CHANNELS_DEF = 2;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_LENGTH   = 2'd2;

  // Register reset values
  localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 16'd256;
  localparam logic [CHCNT_W-1:0]    CHCNT_RST    = 2'd2;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [CHCNT_W-1:0]         chcnt_t;

endpackage

`default_nettype wire

FILE: hw/rtl/waveform_peak_decimator.sv
// Min/max peak decimator for waveform display.
// Input channel (in_valid/in_ready): one audio frame per beat, a signed
// 16-bit sample for each of up to two channels.
// Result channel (out_valid/out_ready): one peak per active channel on an
// emitting frame, channel zero first, with the frame position and a flag on
// the last peak of the frame. Frames that do not emit give no beat.
// Configuration: cfg_we writes cfg_wdata into register cfg_addr at once
// (0 interval, 1 channel count, 2 loop length).
// A frame enters the input register, its first peak then the result register.
// Throughput: one frame per cycle when it emits nothing or a single peak and
// no stall or reduction holds it; a two-channel emitting frame holds the
// single result port until its second peak is taken. A write of a nonzero
// loop length starts a bit-serial reduction of the loop position modulo the
// new length; no frame is processed meanwhile, and at most one waits in the
// input register. Reset (rst_n low, synchronous) restores the register
// defaults, clears the extremes, the other counters and the pipeline, presets
// the frame counter to the reset interval and leaves no result pending. A
// stalled receiver holds the result register; the input register behind it
// then keeps one frame and in_ready stays low until the result port frees.

`default_nettype none

module waveform_peak_decimator
  import wpd_pkg::*;
#(
  parameter int unsigned MAX_CHANNELS = MAX_CHANNELS_DEF
) (
  input  wire                     clk,
  input  wire                     rst_n,
  // input channel
  input  wire                     in_valid,
  output logic                    in_ready,
  input  wire  signed [15:0]      in_sample_first,
  input  wire  signed [15:0]      in_sample_second,
  // result channel
  output logic                    out_valid,
  input  wire                     out_ready,
  output logic signed [15:0]      out_peak_value,
  output logic [31:0]             out_frame_position,
  output logic                    out_channel_index,
  output logic                    out_last_of_run,
  // configuration port
  input  wire                     cfg_we,
  input  wire  [CFG_IDX_W-1:0]    cfg_addr,
  input  wire  [CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int unsigned LAST_CH = MAX_CHANNELS - 1;

  // Configuration registers
  logic [INTERVAL_W-1:0] interval_r;
  chcnt_t                chcnt_r;
  logic [LOOP_W-1:0]     loop_len_r;

  // Block state
  sample_t               max_r [MAX_CHANNELS];
  sample_t               min_r [MAX_CHANNELS];
  logic [INTERVAL_W-1:0] frame_cnt_r;
  logic                  parity_r;
  logic [POS_W-1:0]      frame_idx_r;
  logic [LOOP_W-1:0]     residue_r;

  // Input register
  logic                  s1_valid_r;
  sample_t               s1_first_r;
  sample_t               s1_second_r;

  // Result register and the second peak of a two-channel frame
  logic                  out_valid_r;
  sample_t               out_peak_r;
  logic [POS_W-1:0]      out_pos_r;
  logic                  out_ch_r;
  logic                  out_last_r;
  logic                  sec_pend_r;
  sample_t               sec_peak_r;

  // Bit-serial modulo unit
  logic                  red_busy_r;
  logic [4:0]            red_cnt_r;
  logic [LOOP_W:0]       red_rem_r;
  logic [LOOP_W-1:0]     red_dvd_r;

  logic                  adv;
  logic                  free_nxt;
  logic                  out_take;
  chcnt_t                n_act;
  logic                  loop_hit;
  logic                  emit;
  logic [LOOP_W-1:0]     residue_nxt;
  logic [LOOP_W:0]       res_sum;
  logic [LOOP_W:0]       red_shift;
  logic                  red_ge;
  sample_t               smp  [2];
  sample_t               peak [MAX_CHANNELS];
  sample_t               max_nxt [MAX_CHANNELS];
  sample_t               min_nxt [MAX_CHANNELS];

  // Handshake: the input register moves on when the result side has room and no reduction runs
  assign out_take = out_valid_r && out_ready;
  assign free_nxt = !out_valid_r || (out_ready && !sec_pend_r);
  assign adv      = s1_valid_r && free_nxt && !red_busy_r;
  assign in_ready = !s1_valid_r || adv;

  // Channels in use, clamped to the supported range
  always_comb begin
    if (chcnt_r == '0) begin
      n_act = chcnt_t'(1);
    end else if (chcnt_r > chcnt_t'(MAX_CHANNELS)) begin
      n_act = chcnt_t'(MAX_CHANNELS);
    end else begin
      n_act = chcnt_r;
    end
  end

  // Loop position: the residue is always below the loop length here
  assign loop_hit = (loop_len_r != '0) && (residue_r == '0);
  assign res_sum  = {1'b0, residue_r} + {{(LOOP_W + 1 - CHCNT_W){1'b0}}, n_act};

  always_comb begin
    if (loop_len_r == '0) begin
      residue_nxt = '0;
    end else if (loop_len_r == LOOP_W'(1)) begin
      residue_nxt = '0;
    end else if (res_sum >= {1'b0, loop_len_r}) begin
      residue_nxt = LOOP_W'(res_sum - {1'b0, loop_len_r});
    end else begin
      residue_nxt = res_sum[LOOP_W-1:0];
    end
  end

  assign emit = (frame_cnt_r >= interval_r) || loop_hit;

  assign smp[0] = s1_first_r;
  assign smp[1] = s1_second_r;

  // Per-channel extreme tracking and peak choice
  for (genvar i = 0; i < MAX_CHANNELS; i++) begin : g_ch
    sample_t mx_upd;
    sample_t mn_upd;
    logic    active;

    assign active = chcnt_t'(i) < n_act;

    always_comb begin
      mx_upd = max_r[i];
      mn_upd = min_r[i];
      if (smp[i] > max_r[i]) begin
        mx_upd = smp[i];
      end else if (smp[i] < min_r[i]) begin
        mn_upd = smp[i];
      end
    end

    // A zero extreme gives way to the other one
    always_comb begin
      if (parity_r) begin
        peak[i] = (mn_upd == '0) ? mx_upd : mn_upd;
      end else begin
        peak[i] = (mx_upd == '0) ? mn_upd : mx_upd;
      end
    end

    always_comb begin
      max_nxt[i] = max_r[i];
      min_nxt[i] = min_r[i];
      if (adv && active) begin
        if (emit) begin
          max_nxt[i] = '0;
          min_nxt[i] = '0;
        end else begin
          max_nxt[i] = mx_upd;
          min_nxt[i] = mn_upd;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        max_r[i] <= '0;
        min_r[i] <= '0;
      end else begin
        max_r[i] <= max_nxt[i];
        min_r[i] <= min_nxt[i];
      end
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_first_r  <= in_sample_first;
      s1_second_r <= in_sample_second;
    end
  end

  // Configuration registers and frame counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r  <= INTERVAL_RST;
      chcnt_r     <= CHCNT_RST;
      loop_len_r  <= '0;
      frame_cnt_r <= INTERVAL_RST;
      parity_r    <= 1'b0;
      frame_idx_r <= '0;
    end else begin
      if (adv) begin
        frame_idx_r <= frame_idx_r + POS_W'(1);
        if (emit) begin
          frame_cnt_r <= '0;
          parity_r    <= ~parity_r;
        end else if (frame_cnt_r != '1) begin
          frame_cnt_r <= frame_cnt_r + INTERVAL_W'(1);
        end
      end
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_INTERVAL: begin
            interval_r  <= cfg_wdata[INTERVAL_W-1:0];
            frame_cnt_r <= cfg_wdata[INTERVAL_W-1:0];
          end
          REG_CHANNEL_COUNT: begin
            chcnt_r <= cfg_wdata[CHCNT_W-1:0];
          end
          REG_LOOP_LENGTH: begin
            loop_len_r <= cfg_wdata[LOOP_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Modulo unit: one restoring step a cycle, restarted by each nonzero length write
  assign red_shift = {red_rem_r[LOOP_W-1:0], red_dvd_r[LOOP_W-1]};
  assign red_ge    = red_shift >= {1'b0, loop_len_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_busy_r <= 1'b0;
      red_cnt_r  <= '0;
      residue_r  <= '0;
    end else if (cfg_we && (cfg_addr == REG_LOOP_LENGTH)) begin
      red_busy_r <= (cfg_wdata[LOOP_W-1:0] != '0);
      red_cnt_r  <= '0;
    end else if (red_busy_r) begin
      red_cnt_r <= red_cnt_r + 5'd1;
      if (red_cnt_r == '1) begin
        red_busy_r <= 1'b0;
        residue_r  <= red_ge ? LOOP_W'(red_shift - {1'b0, loop_len_r})
                             : red_shift[LOOP_W-1:0];
      end
    end else if (adv) begin
      residue_r <= residue_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cfg_we && (cfg_addr == REG_LOOP_LENGTH)) begin
      red_rem_r <= '0;
      red_dvd_r <= residue_r;
    end else if (red_busy_r) begin
      red_rem_r <= red_ge ? (red_shift - {1'b0, loop_len_r}) : red_shift;
      red_dvd_r <= {red_dvd_r[LOOP_W-2:0], 1'b0};
    end
  end

  // Result register: channel zero first, then the held second peak
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sec_pend_r  <= 1'b0;
    end else if (adv && emit) begin
      out_valid_r <= 1'b1;
      sec_pend_r  <= (n_act == chcnt_t'(2));
    end else if (out_take) begin
      out_valid_r <= sec_pend_r;
      sec_pend_r  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) begin
      out_peak_r <= peak[0];
      out_pos_r  <= frame_idx_r;
      out_ch_r   <= 1'b0;
      out_last_r <= (n_act == chcnt_t'(1));
      sec_peak_r <= peak[LAST_CH];
    end else if (out_take && sec_pend_r) begin
      out_peak_r <= sec_peak_r;
      out_ch_r   <= 1'b1;
      out_last_r <= 1'b1;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_peak_value     = out_peak_r;
  assign out_frame_position = out_pos_r;
  assign out_channel_index  = out_ch_r;
  assign out_last_of_run    = out_last_r;

  // A held second peak always sits behind a shown first one
  a_sec_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    sec_pend_r |-> out_valid_r)
    else $error("second peak pending without a result shown");

  // No frame is processed while the loop position is being reduced
  a_no_adv_busy: assert property (@(posedge clk) disable iff (!rst_n)
    red_busy_r |-> !adv)
    else $error("frame processed during modulo reduction");

  // The loop position is reduced before any frame uses it
  a_residue_range: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && (loop_len_r != '0)) |-> (residue_r < loop_len_r))
    else $error("loop position not below loop length");

  // An emission restarts the frame counter
  a_cnt_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && emit && !cfg_we) |=> (frame_cnt_r == '0))
    else $error("frame counter not cleared after emission");

  // A shown result only changes once it has been taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_peak_r)
                                     && $stable(out_ch_r)))
    else $error("result changed while stalled");

endmodule

`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import wpd_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned REPORT_LIMIT  = 10;
  localparam int unsigned RANDOM_PHASES = 14;
  localparam int unsigned PHASE_FRAMES  = 100;

  // One peak beat as the result channel carries it.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] peak;
    logic [POS_W-1:0]           pos;
    logic                       chan;
    logic                       last;
  } peak_rec_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  wire                    in_ready;
  sample_t                in_sample_first;
  sample_t                in_sample_second;
  wire                    out_valid;
  logic                   out_ready;
  wire signed [15:0]      out_peak_value;
  wire [31:0]             out_frame_position;
  wire                    out_channel_index;
  wire                    out_last_of_run;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_addr;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  // Predicted peaks waiting for their beat on the result channel.
  peak_rec_t   expected_peaks[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  bit          no_idle;
  int unsigned hold_request;

  // Shadow of the decimator state and its registers.
  sample_t              hi_peak [2];
  sample_t              lo_peak [2];
  logic [15:0]          span_count;
  logic                 emit_odd;
  logic [POS_W-1:0]     frame_pos;
  logic [LOOP_W-1:0]    loop_pos;
  logic [INTERVAL_W-1:0] cur_interval;
  chcnt_t               cur_channels;
  logic [LOOP_W-1:0]    cur_loop;

  waveform_peak_decimator DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_sample_first    (in_sample_first),
    .in_sample_second   (in_sample_second),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_peak_value     (out_peak_value),
    .out_frame_position (out_frame_position),
    .out_channel_index  (out_channel_index),
    .out_last_of_run    (out_last_of_run),
    .cfg_we             (cfg_we),
    .cfg_addr           (cfg_addr),
    .cfg_wdata          (cfg_wdata)
  );

  always #10 clk = ~clk;

  // Out-of-range channel counts fold onto the nearest legal value.
  function automatic int unsigned live_channels();
    if (cur_channels == 0) return 1;
    if (cur_channels > MAX_CHANNELS_DEF) return MAX_CHANNELS_DEF;
    return cur_channels;
  endfunction

  function automatic void clear_shadow();
    cur_interval = INTERVAL_RST;
    cur_channels = CHCNT_RST;
    cur_loop     = '0;
    hi_peak[0]   = '0;
    hi_peak[1]   = '0;
    lo_peak[0]   = '0;
    lo_peak[1]   = '0;
    span_count   = INTERVAL_RST;
    emit_odd     = 1'b0;
    frame_pos    = '0;
    loop_pos     = '0;
    expected_peaks.delete();
  endfunction

  function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_INTERVAL: begin
        cur_interval = data[INTERVAL_W-1:0];
        span_count   = data[INTERVAL_W-1:0];
      end
      REG_CHANNEL_COUNT: cur_channels = data[CHCNT_W-1:0];
      REG_LOOP_LENGTH:   cur_loop = data[LOOP_W-1:0];
      default: ;
    endcase
  endfunction

  // Update the extremes for one frame and queue the peaks it emits.
  function automatic void predict_frame(input sample_t s0, input sample_t s1);
    sample_t     s [2];
    int unsigned n;
    int unsigned ch;
    logic        loop_hit;
    logic [63:0] rem;
    peak_rec_t   rec;
    s[0]     = s0;
    s[1]     = s1;
    n        = live_channels();
    loop_hit = 1'b0;
    for (ch = 0; ch < n; ch++) begin
      if (s[ch] > hi_peak[ch]) hi_peak[ch] = s[ch];
      else if (s[ch] < lo_peak[ch]) lo_peak[ch] = s[ch];
    end
    // The loop position is reduced by the current length before each compare.
    if (cur_loop != 0) begin
      rem      = 64'(loop_pos) % 64'(cur_loop);
      loop_hit = (rem == 0);
      loop_pos = 32'((rem + 64'(n)) % 64'(cur_loop));
    end else begin
      loop_pos = '0;
    end
    if (span_count >= cur_interval || loop_hit) begin
      for (ch = 0; ch < n; ch++) begin
        if (hi_peak[ch] == 0 && lo_peak[ch] != 0) hi_peak[ch] = lo_peak[ch];
        else if (lo_peak[ch] == 0 && hi_peak[ch] != 0) lo_peak[ch] = hi_peak[ch];
        rec.peak = emit_odd ? lo_peak[ch] : hi_peak[ch];
        rec.pos  = frame_pos;
        rec.chan = 1'(ch);
        rec.last = (ch + 1 == n);
        expected_peaks.push_back(rec);
        hi_peak[ch] = '0;
        lo_peak[ch] = '0;
      end
      span_count = '0;
      emit_odd   = ~emit_odd;
    end else if (span_count != 16'hFFFF) begin
      span_count = span_count + 16'd1;
    end
    frame_pos = frame_pos + 32'd1;
  endfunction

  function automatic void report_peak(input bit has_want, input peak_rec_t want,
                                      input peak_rec_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      if (has_want)
        $display("peak mismatch: expected peak %0d pos %0d ch %0d last %0d, got %0d %0d %0d %0d",
                 want.peak, want.pos, want.chan, want.last,
                 got.peak, got.pos, got.chan, got.last);
      else
        $display("unexpected peak: got peak %0d pos %0d ch %0d last %0d",
                 got.peak, got.pos, got.chan, got.last);
    end
  endfunction

  // Compare each result beat with the oldest prediction, then follow the
  // register writes and accepted input beats of this edge.
  always @(posedge clk) begin
    peak_rec_t want;
    peak_rec_t got;
    if (!rst_n) begin
      clear_shadow();
    end else begin
      if (out_valid && out_ready) begin
        got = {out_peak_value, out_frame_position, out_channel_index, out_last_of_run};
        if (expected_peaks.size() == 0) begin
          report_peak(1'b0, '0, got);
        end else begin
          want = expected_peaks.pop_front();
          if (got.peak !== want.peak || got.pos !== want.pos ||
              got.chan !== want.chan || got.last !== want.last)
            report_peak(1'b1, want, got);
        end
      end
      if (cfg_we) apply_register(cfg_addr, cfg_wdata);
      if (in_valid && in_ready) predict_frame(in_sample_first, in_sample_second);
    end
  end

  // Run watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result side: a random hold-off before each beat, or a long one on request.
  initial begin : result_sink
    int unsigned gap;
    out_ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (hold_request != 0) begin
        gap          = hold_request;
        hold_request = 0;
      end else begin
        gap = no_idle ? 0 : $urandom_range(0, 5);
      end
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      @(negedge clk);
    end
  end

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 7))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return '0;
      3:       return sample_t'(int'($urandom_range(0, 8)) - 4);
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Offer one frame after a random gap and wait for its beat. Valid is left
  // high on return, so back-to-back frames see no gap in valid.
  task automatic send_frame(input sample_t s0, input sample_t s1);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_sample_first  <= s0;
    in_sample_second <= s1;
    do @(posedge clk); while (in_ready !== 1'b1);
    @(negedge clk);
  endtask

  task automatic send_random_frames(input int unsigned count);
    repeat (count) send_frame(pick_sample(), pick_sample());
  endtask

  // Stop offering frames and wait until every predicted peak has arrived.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_peaks.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // The first frame after reset emits; then full-scale and sign edge cases
  // with every frame emitting.
  task automatic check_extremes();
    send_frame(16'sh7FFF, 16'sh8000);
    send_random_frames(3);
    settle();
    write_reg(REG_INTERVAL, 0);
    send_frame('0, '0);
    send_frame(16'sh8000, 16'sh7FFF);
    send_frame(-16'sd1, 16'sd1);
    send_frame(16'sd1, -16'sd1);
    send_frame(16'sh5555, sample_t'(16'hAAAA));
    send_frame('0, '0);
    settle();
  endtask

  // Channel counts of zero and three fold onto one and two; an unused
  // channel keeps its extremes until it is in use again.
  task automatic check_channel_counts();
    chcnt_t counts [7];
    int     i;
    counts = '{2'd2, 2'd2, 2'd1, 2'd3, 2'd3, 2'd0, 2'd0};
    write_reg(REG_INTERVAL, 1);
    for (i = 0; i < 7; i++) begin
      write_reg(REG_CHANNEL_COUNT, counts[i]);
      send_frame(pick_sample(), pick_sample());
      settle();
    end
    write_reg(REG_CHANNEL_COUNT, 2);
  endtask

  // The largest interval: the write makes the next frame emit, then silence.
  task automatic check_interval_limits();
    write_reg(REG_INTERVAL, 16'hFFFF);
    send_random_frames(3);
    settle();
  endtask

  // Loop points with the interval out of reach, including a length change
  // part way through the stream and a return to no looping.
  task automatic check_loop_points();
    write_reg(REG_INTERVAL, 16'hFFFF);
    write_reg(REG_LOOP_LENGTH, 1);
    send_random_frames(2);
    settle();
    write_reg(REG_LOOP_LENGTH, 3);
    send_random_frames(3);
    settle();
    write_reg(REG_LOOP_LENGTH, 32'hFFFF_FFFF);
    send_random_frames(2);
    settle();
    write_reg(REG_LOOP_LENGTH, 0);
    send_random_frames(1);
    settle();
  endtask

  // Every frame emits two peaks while the result side holds off for a long
  // stretch, so the block fills up and stalls its input.
  task automatic check_backpressure();
    write_reg(REG_INTERVAL, 0);
    write_reg(REG_CHANNEL_COUNT, 2);
    hold_request = HOLD_CYCLES;
    send_random_frames(40);
    settle();
  endtask

  // Phases of random frames, each under a freshly drawn configuration.
  task automatic check_random_traffic();
    int unsigned          phase;
    logic [CFG_DATA_W-1:0] value;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      no_idle = (phase % 4 == 3);
      case ($urandom_range(0, 5))
        0:       value = 0;
        1:       value = $urandom_range(1, 3);
        2:       value = $urandom_range(4, 40);
        3:       value = 16'hFFFF;
        4:       value = $urandom_range(0, 65535);
        default: value = $urandom_range(0, 8);
      endcase
      write_reg(REG_INTERVAL, value);
      write_reg(REG_CHANNEL_COUNT, $urandom_range(0, 3));
      case ($urandom_range(0, 5))
        0, 1:    value = 0;
        2:       value = $urandom_range(1, 16);
        3:       value = 32'hFFFF_FFFF;
        4:       value = $urandom;
        default: value = $urandom_range(17, 300);
      endcase
      write_reg(REG_LOOP_LENGTH, value);
      send_random_frames(PHASE_FRAMES);
      settle();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    clk              = 1'b0;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_sample_first  = '0;
    in_sample_second = '0;
    cfg_we           = 1'b0;
    cfg_addr         = REG_INTERVAL;
    cfg_wdata        = '0;
    no_idle          = 1'b0;
    hold_request     = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    check_extremes();
    check_channel_counts();
    check_interval_limits();
    check_loop_points();
    check_backpressure();
    check_random_traffic();
    settle();
    if (mismatch_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
